### hdl/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared constants for the 3x3 local binary pattern stream.
// ----------------------------------------------------------------------------
package lbp_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 16;
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 16;
    localparam int LINE_W    = 2 * PIX_W;

    localparam logic [WIDTH_W-1:0]  MIN_WIDTH_V  = WIDTH_W'(3);
    localparam logic [WIDTH_W-1:0]  MAX_WIDTH_V  = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] MIN_HEIGHT_V = HEIGHT_W'(3);
    localparam logic [WIDTH_W-1:0]  RST_WIDTH    = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT   = HEIGHT_W'(480);

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

endpackage

### hdl/lbp_ram.sv
// ----------------------------------------------------------------------------
// lbp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/lbp_3x3_code_stream.sv
// ----------------------------------------------------------------------------
// lbp_3x3_code_stream
// Streaming 3x3 local binary pattern coder with two line stores.
// ----------------------------------------------------------------------------
// Pixels enter on the slave stream (i_s_*) in raster order, one per request.
// For every interior pixel one 8-bit code leaves on the master stream
// (o_m_*); border pixels give none, so a frame yields (w-2)*(h-2) codes.
// o_m_tlast marks the final code of the frame. Frame size is set through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write it only while
// idle, which the block does not enforce. Throughput: one pixel per
// cycle unless input is stalled. Both line stores share one 16-bit RAM
// addressed by column; it is read one column ahead, so the row data for
// the next pixel is ready when that pixel arrives. A code appears on the
// master side in the cycle after the pixel that completes its window is
// accepted. A single output register parts the two sides; while it holds
// a code the receiver has not taken, input is stalled.
// Reset (synchronous, active low) clears the counters, window and output
// valid, and sets the size to 640 x 480. No clearing pass is needed.
// ----------------------------------------------------------------------------
module lbp_3x3_code_stream (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [lbp_pkg::PIX_W-1:0]    i_s_tdata,   // [7:0] pixel
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [lbp_pkg::PIX_W-1:0]    o_m_tdata,   // [7:0] lbp_code
    output logic                         o_m_tlast,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [lbp_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int COL_W = lbp_pkg::COL_W;
    localparam int WW    = lbp_pkg::WIDTH_W;
    localparam int HW    = lbp_pkg::HEIGHT_W;
    localparam int PW    = lbp_pkg::PIX_W;

    logic [WW-1:0]    r_width;
    logic [HW-1:0]    r_height;
    logic [COL_W-1:0] r_col, n_col;
    logic [HW-1:0]    r_row, n_row;
    logic [PW-1:0]    r_win [6];
    logic             r_m_valid;
    logic [PW-1:0]    r_m_code;
    logic             r_m_last;

    logic [WW-1:0]    eff_w;
    logic [HW-1:0]    eff_h;
    logic             accept;
    logic [lbp_pkg::LINE_W-1:0] line_rd;
    logic [PW-1:0]    top, mid, pix, ctr;
    logic             interior;
    logic [PW-1:0]    code;
    logic             last;
    logic             col_end, row_end;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= lbp_pkg::RST_WIDTH;
            r_height <= lbp_pkg::RST_HEIGHT;
        end else if (i_cfg_we) begin
            case (lbp_pkg::t_reg_idx'(i_cfg_idx))
                lbp_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WW-1:0];
                lbp_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg_data[HW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_width < lbp_pkg::MIN_WIDTH_V) begin
            eff_w = lbp_pkg::MIN_WIDTH_V;
        end else if (r_width > lbp_pkg::MAX_WIDTH_V) begin
            eff_w = lbp_pkg::MAX_WIDTH_V;
        end else begin
            eff_w = r_width;
        end
        eff_h = (r_height < lbp_pkg::MIN_HEIGHT_V) ? lbp_pkg::MIN_HEIGHT_V : r_height;
    end

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    assign col_end = ({1'b0, r_col} + (COL_W+1)'(1)) >= (COL_W+1)'(eff_w);
    assign row_end = ({1'b0, r_row} + (HW+1)'(1)) >= {1'b0, eff_h};

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + HW'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    // line stores: [7:0] row r-2, [15:8] row r-1; read one column ahead
    lbp_ram #(
        .WIDTH (lbp_pkg::LINE_W),
        .DEPTH (lbp_pkg::MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata ({pix, mid}),
        .i_raddr (n_col),
        .o_rdata (line_rd)
    );

    assign top = line_rd[PW-1:0];
    assign mid = line_rd[2*PW-1:PW];
    assign pix = i_s_tdata;
    assign ctr = r_win[1];

    assign interior = (r_row >= HW'(2)) && (r_col >= COL_W'(2))
                   && (r_row < eff_h) && ({1'b0, r_col} < eff_w);

    always_comb begin
        code[7] = r_win[3] >= ctr;
        code[6] = r_win[0] >= ctr;
        code[5] = top      >= ctr;
        code[4] = mid      >= ctr;
        code[3] = pix      >= ctr;
        code[2] = r_win[2] >= ctr;
        code[1] = r_win[5] >= ctr;
        code[0] = r_win[4] >= ctr;
    end

    assign last = ({1'b0, r_col} == eff_w - WW'(1)) && (r_row == eff_h - HW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_m_valid <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (accept) begin
                r_win[3] <= r_win[0];
                r_win[4] <= r_win[1];
                r_win[5] <= r_win[2];
                r_win[0] <= top;
                r_win[1] <= mid;
                r_win[2] <= pix;
                r_m_valid <= interior;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_m_code <= code;
            r_m_last <= last;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_code;
    assign o_m_tlast  = r_m_last;

endmodule
